// ===== hdl/bfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the bit field packer.
// Depends on nothing; used by the controller, the datapath and the top level.
package bfp_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned WidthBits  = 6;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned PendBits   = ByteBits - 1;
  // Pending bits plus one full field: at most 39 bits in flight.
  localparam int unsigned AccWidth   = FieldWidth + PendBits;
  localparam int unsigned CntWidth   = 6;

  localparam logic [WidthBits-1:0] MaxFieldWidth = WidthBits'(FieldWidth);
  localparam logic [CntWidth-1:0]  ByteCount     = CntWidth'(ByteBits);
  localparam logic [CntWidth-1:0]  TwoByteCount  = CntWidth'(2 * ByteBits);

  typedef struct packed {
    logic load;   // Merge the accepted field into the accumulator.
    logic shift;  // Drop the byte that was just delivered.
  } bfp_cmd_t;

  typedef struct packed {
    logic width_ok;   // Field width is within 1 to 32.
    logic load_full;  // The merge would complete at least one byte.
    logic last;       // The byte on the output is the last of this transaction.
  } bfp_status_t;

  function automatic logic [FieldWidth-1:0] bit_reverse(input logic [FieldWidth-1:0] v);
    logic [FieldWidth-1:0] r;
    for (int i = 0; i < FieldWidth; i++) begin
      r[i] = v[FieldWidth-1-i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/bit_field_packer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bit field packer: controller plus datapath.
// Depends on bfp_pkg, bfp_ctrl and bfp_datapath.

// Appends the low field_width_i bits of field_value_i (bit-reversed first when
// msb_first_i is set) above up to seven pending bits and delivers every completed
// byte, earliest bits in bit 0, with last_byte_o on the final byte of the input
// transaction. A transaction whose width is 0 or above 32 is dropped. One input
// transaction is handled at a time: it is taken, then its 0 to 4 bytes leave from
// the accumulator register at one per cycle while the output side is ready. The
// single accumulator, which must drain before the next transaction is taken, and
// the one-byte output port keep the block from taking a new transaction before all
// bytes of the last one have left.
module bit_field_packer_unit import bfp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FieldWidth-1:0] field_value_i,
  input  logic [WidthBits-1:0]  field_width_i,
  input  logic                  msb_first_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ByteBits-1:0]   out_byte_o,
  output logic                  last_byte_o
);

  bfp_cmd_t    cmd;
  bfp_status_t status;

  bfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  bfp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .field_value_i (field_value_i),
    .field_width_i (field_width_i),
    .msb_first_i   (msb_first_i),
    .status_o      (status),
    .out_byte_o    (out_byte_o)
  );

  assign last_byte_o = status.last;

endmodule

// ===== hdl/bfp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the bit field packer: sequences loading and byte delivery.
// Depends on bfp_pkg.
module bfp_ctrl import bfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        out_ready_i,
  input  bfp_status_t status_i,
  output bfp_cmd_t    cmd_o,
  output logic        in_ready_o,
  output logic        out_valid_o
);

  typedef enum logic [0:0] {
    StIdle,
    StEmit
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   out_fire;

  assign in_fire  = in_valid_i && in_ready_q;
  assign out_fire = out_valid_q && out_ready_i;

  assign cmd_o.load  = in_fire && status_i.width_ok;
  assign cmd_o.shift = out_fire;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          // A transaction that completes no byte only updates the pending bits.
          if (in_fire && status_i.width_ok && status_i.load_full) begin
            state_q     <= StEmit;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        StEmit: begin
          if (out_fire && status_i.last) begin
            state_q     <= StIdle;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= StIdle;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/bfp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the bit field packer: field alignment and the LSB-first accumulator.
// Depends on bfp_pkg.
module bfp_datapath import bfp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfp_cmd_t              cmd_i,
  input  logic [FieldWidth-1:0] field_value_i,
  input  logic [WidthBits-1:0]  field_width_i,
  input  logic                  msb_first_i,
  output bfp_status_t           status_o,
  output logic [ByteBits-1:0]   out_byte_o
);

  logic [AccWidth-1:0]   acc_q, acc_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [4:0]            drop;
  logic [FieldWidth-1:0] field;
  logic [CntWidth-1:0]   merged_count;

  // Keeping or reversing the low bits both use one right shift by 32 - width: of the mask or of the reversed value.
  assign drop  = 5'(MaxFieldWidth - field_width_i);
  assign field = msb_first_i ? (bit_reverse(field_value_i) >> drop)
                             : (field_value_i & ({FieldWidth{1'b1}} >> drop));

  assign merged_count = {{(CntWidth-3){1'b0}}, count_q[2:0]} + CntWidth'(field_width_i);

  assign status_o.width_ok  = (field_width_i != '0) && (field_width_i <= MaxFieldWidth);
  assign status_o.load_full = merged_count >= ByteCount;
  assign status_o.last      = count_q < TwoByteCount;

  assign out_byte_o = acc_q[ByteBits-1:0];

  // Bits above the pending count are always zero, so the merge is a plain OR.
  always_comb begin
    acc_d   = acc_q;
    count_d = count_q;
    if (cmd_i.load) begin
      acc_d   = {{FieldWidth{1'b0}}, acc_q[PendBits-1:0]}
              | ({{PendBits{1'b0}}, field} << count_q[2:0]);
      count_d = merged_count;
    end else if (cmd_i.shift) begin
      acc_d   = acc_q >> ByteBits;
      count_d = count_q - ByteCount;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      count_q <= '0;
    end else begin
      acc_q   <= acc_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hdl/bfp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the bit field packer and its bind to the top level.
// Depends on bfp_pkg and bit_field_packer_unit.
module bfp_checker import bfp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [WidthBits-1:0]  field_width_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ByteBits-1:0]   out_byte_o,
  input logic                  last_byte_o
);

  // A stalled output byte holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_byte_o))
    else $error("output transaction changed while stalled");

  // Input is never taken while bytes of the previous transaction are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output valid");

  // The last byte closes the burst and reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_byte_o |=> in_ready_o && !out_valid_o)
    else $error("input not reopened after last byte");

  // A byte that is not last is followed by another byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_byte_o |=> out_valid_o && !in_ready_o)
    else $error("burst ended without last byte");

  // A transaction with width zero produces nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (field_width_i == '0) |=> in_ready_o && !out_valid_o)
    else $error("zero-width transaction produced output");

endmodule

bind bit_field_packer_unit bfp_checker u_bfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .field_width_i (field_width_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .last_byte_o   (last_byte_o)
);
